[rtl/core/robot_arm_forward_kinematics_unit_macros.svh]
// ----------------------------------------------------------------------------
// Robot arm forward kinematics assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ROBOT_ARM_FORWARD_KINEMATICS_UNIT_MACROS_SVH
`define ROBOT_ARM_FORWARD_KINEMATICS_UNIT_MACROS_SVH

// same-cycle implication
`define RAFK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAFK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rafk_pkg.sv]
// ----------------------------------------------------------------------------
// Robot arm forward kinematics package
// Types, constants and rounding helpers of the forward kinematics pipeline.
// ----------------------------------------------------------------------------
package rafk_pkg;

  localparam int NUM_JOINTS = 6;
  localparam int NUM_SC     = 2 * NUM_JOINTS;   // sine and cosine per joint
  localparam int ANGLE_W    = 26;
  localparam int LEN_W      = 26;
  localparam int ROT_W      = 32;
  localparam int POS_W      = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int ROT_FRAC_BITS_DEF   = 30;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic signed [31:0]        q30_t;
  typedef logic signed [63:0]        prod_t;
  typedef logic signed [31:0]        pos_acc_t;
  typedef logic [26:0]               div_in_t;
  typedef logic [21:0]               quo_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_ONE_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_TWO_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LENGTH   = 3'd5;

  localparam len_t RST_BASE_HEIGHT      = 26'd9954918;
  localparam len_t RST_SHOULDER_OFFSET  = 26'd7235174;
  localparam len_t RST_WRIST_ONE_OFFSET = 26'd5465702;
  localparam len_t RST_WRIST_TWO_OFFSET = 26'd5334630;
  localparam len_t RST_UPPER_ARM_LENGTH = 26'd15967846;
  localparam len_t RST_FOREARM_LENGTH   = 26'd13959168;

  // exact floor(x / 45) for x < 2^27: (x * DIV45_MUL) >> DIV45_SHIFT
  localparam logic [27:0] DIV45_MUL   = 28'd190887436;
  localparam int          DIV45_SHIFT = 33;
  localparam div_in_t     DIV45_BIAS  = 27'd47185920;  // 45 * 2^20
  localparam quo_t        DIV45_BIAS_Q = 22'd1048576;  // 2^20
  localparam div_in_t     TURN_HALF   = 27'd22;

  localparam q30_t  Q30_ONE   = 32'sd1073741824;
  localparam prod_t HALF_Q30  = 64'sd536870912;
  localparam prod_t ONE_Q30_W = 64'sd1073741824;

  // quarter-wave sine Horner coefficients, highest order first
  localparam logic signed [31:0] SIN_COEF [7] = '{
    32'sd61, 32'sd3864, 32'sd172272, 32'sd5026995, 32'sd85569306,
    32'sd693598668, 32'sd1686629713
  };

  // link twist cos and sin: 0, 90, 0, 0, 90, -90 degrees
  localparam int TWIST_COS [NUM_JOINTS] = '{1, 0, 1, 1, 0, 0};
  localparam int TWIST_SIN [NUM_JOINTS] = '{0, 1, 0, 0, 1, -1};

  function automatic prod_t rnd_q30(input prod_t v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  function automatic q30_t clamp_q30(input prod_t v);
    q30_t r;
    if (v > ONE_Q30_W) begin
      r = Q30_ONE;
    end else if (v < -ONE_Q30_W) begin
      r = -Q30_ONE;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

[rtl/core/robot_arm_forward_kinematics_unit.sv]
// ----------------------------------------------------------------------------
// Robot arm forward kinematics unit
// Six-joint modified-DH chain: joint angles in, 3x4 end-effector pose out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one item: six signed Q10.16
//   joint angles in degrees (any bit pattern, wrapped modulo 360).
//   Output channel out_valid / out_stall returns one item per input: nine
//   rotation entries (ROT_FRAC_BITS fraction bits, clamped to +-1) and the
//   position in signed Q13.16 mm, saturated to 29 bits.
//   Config port cfg_valid / cfg_ready (always ready) writes the six link
//   lengths by cfg_index; write only while the pipeline is empty.
// Timing:
//   28 register stages; one item per cycle is sustained while out_stall is low.
//   Stages: 5 for angle to turn (two reciprocal multiplies by 1/45),
//   10 for the sine/cosine polynomial (mirror, square, seven Horner
//   products, final rounding), two per link product, one for output rounding.
// Stall: each stage advances when it is empty or the next one advances, so
//   bubbles are squeezed out and in_stall rises only when all stages hold
//   items and the output is stalled.
// Reset: rst clears all stage valids and loads the default link lengths.
// ----------------------------------------------------------------------------
module robot_arm_forward_kinematics_unit
  import rafk_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int ROT_FRAC_BITS   = ROT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  angle_t                  joint1_angle,
  input  angle_t                  joint2_angle,
  input  angle_t                  joint3_angle,
  input  angle_t                  joint4_angle,
  input  angle_t                  joint5_angle,
  input  angle_t                  joint6_angle,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ROT_W-1:0] rot_xx,
  output logic signed [ROT_W-1:0] rot_xy,
  output logic signed [ROT_W-1:0] rot_xz,
  output logic signed [ROT_W-1:0] rot_yx,
  output logic signed [ROT_W-1:0] rot_yy,
  output logic signed [ROT_W-1:0] rot_yz,
  output logic signed [ROT_W-1:0] rot_zx,
  output logic signed [ROT_W-1:0] rot_zy,
  output logic signed [ROT_W-1:0] rot_zz,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

`include "robot_arm_forward_kinematics_unit_macros.svh"

  localparam int NST        = 28;
  localparam int TURN_SHIFT = 29 - ANGLE_FRAC_BITS;
  localparam int RSH        = 30 - ROT_FRAC_BITS;
  localparam prod_t RHALF   = (RSH == 0) ? 64'sd0 : (64'sd1 <<< (RSH - 1));
  localparam prod_t RONE    = 64'sd1 <<< ROT_FRAC_BITS;
  localparam prod_t POS_HI  = 64'sd268435455;
  localparam prod_t POS_LO  = -64'sd268435456;
  localparam int SC0 = 15;          // stage of finished sine/cosine
  localparam int LK0 = 16;          // first link stage
  localparam int SCN = 2 * NUM_JOINTS - 2;  // index of the last carried sine/cosine

  // ---------------- configuration registers ----------------
  len_t base_height, shoulder_offset, wrist_one_offset, wrist_two_offset;
  len_t upper_arm_length, forearm_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height      <= RST_BASE_HEIGHT;
      shoulder_offset  <= RST_SHOULDER_OFFSET;
      wrist_one_offset <= RST_WRIST_ONE_OFFSET;
      wrist_two_offset <= RST_WRIST_TWO_OFFSET;
      upper_arm_length <= RST_UPPER_ARM_LENGTH;
      forearm_length   <= RST_FOREARM_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_HEIGHT:      base_height      <= cfg_data[LEN_W-1:0];
        REG_SHOULDER_OFFSET:  shoulder_offset  <= cfg_data[LEN_W-1:0];
        REG_WRIST_ONE_OFFSET: wrist_one_offset <= cfg_data[LEN_W-1:0];
        REG_WRIST_TWO_OFFSET: wrist_two_offset <= cfg_data[LEN_W-1:0];
        REG_UPPER_ARM_LENGTH: upper_arm_length <= cfg_data[LEN_W-1:0];
        REG_FOREARM_LENGTH:   forearm_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // link length a and offset d per joint; the rest are zero
  len_t len_a [NUM_JOINTS];
  len_t len_d [NUM_JOINTS];
  assign len_a = '{'0, '0, upper_arm_length, forearm_length, '0, '0};
  assign len_d = '{base_height, '0, '0, shoulder_offset, wrist_one_offset,
                   wrist_two_offset};

  // ---------------- stage valids and advance chain ----------------
  logic [1:NST] vld;
  logic [1:NST] ld;

  always_comb begin
    ld[NST] = !vld[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- angle to turn fraction ----------------
  // turn = floor((a * 2^(29-F) + 22) / 45) mod 2^32, done as
  // a = 45*qa + ra, then qa * 2^(29-F) + floor((ra * 2^(29-F) + 22) / 45)
  angle_t ang [NUM_JOINTS];
  assign ang = '{joint1_angle, joint2_angle, joint3_angle, joint4_angle,
                 joint5_angle, joint6_angle};

  div_in_t            a1_x  [NUM_JOINTS];
  div_in_t            a2_x  [NUM_JOINTS];
  quo_t               a2_q1 [NUM_JOINTS];
  div_in_t            a3_y  [NUM_JOINTS];
  logic signed [21:0] a3_qa [NUM_JOINTS];
  quo_t               a4_q2 [NUM_JOINTS];
  logic signed [21:0] a4_qa [NUM_JOINTS];
  logic [31:0]        a5_turn [NUM_JOINTS];

  logic [54:0] div1_p [NUM_JOINTS];
  logic [54:0] div2_p [NUM_JOINTS];
  logic [5:0]  a3_ra  [NUM_JOINTS];

  always_comb begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      div1_p[j] = 55'(a1_x[j]) * 55'(DIV45_MUL);
      div2_p[j] = 55'(a3_y[j]) * 55'(DIV45_MUL);
      a3_ra[j]  = 6'(a2_x[j] - 27'(a2_q1[j]) * 27'd45);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      if (ld[1]) begin
        a1_x[j] <= 27'(ang[j]) + DIV45_BIAS;
      end
      if (ld[2]) begin
        a2_x[j]  <= a1_x[j];
        a2_q1[j] <= 22'(div1_p[j] >> DIV45_SHIFT);
      end
      if (ld[3]) begin
        a3_y[j]  <= (27'(a3_ra[j]) << TURN_SHIFT) + TURN_HALF;
        a3_qa[j] <= $signed(a2_q1[j] - DIV45_BIAS_Q);
      end
      if (ld[4]) begin
        a4_q2[j] <= 22'(div2_p[j] >> DIV45_SHIFT);
        a4_qa[j] <= a3_qa[j];
      end
      if (ld[5]) begin
        a5_turn[j] <= (32'(a4_qa[j]) << TURN_SHIFT) + 32'(a4_q2[j]);
      end
    end
  end

  // ---------------- quarter-wave sine, 12 lanes ----------------
  // even lane: sine of joint, odd lane: cosine (turn plus a quarter)
  logic [1:0]  s0_q  [NUM_SC];
  logic [30:0] s0_t  [NUM_SC];
  logic [1:0]  s1_q  [NUM_SC];
  logic [30:0] s1_t  [NUM_SC];
  logic [61:0] s1_tt [NUM_SC];
  logic [31:0] lane_turn [NUM_SC];

  always_comb begin
    for (int u = 0; u < NUM_SC; u++) begin
      lane_turn[u] = a5_turn[u/2] + ((u % 2 == 1) ? 32'h4000_0000 : 32'h0);
    end
  end

  always_ff @(posedge clk) begin
    for (int u = 0; u < NUM_SC; u++) begin
      if (ld[6]) begin
        s0_q[u] <= lane_turn[u][31:30];
        s0_t[u] <= lane_turn[u][30] ? (31'h4000_0000 - {1'b0, lane_turn[u][29:0]})
                                    : {1'b0, lane_turn[u][29:0]};
      end
      if (ld[7]) begin
        s1_q[u]  <= s0_q[u];
        s1_t[u]  <= s0_t[u];
        s1_tt[u] <= 62'(s0_t[u]) * 62'(s0_t[u]);
      end
    end
  end

  // Horner pipeline: index h sits at stage 8+h
  prod_t             hm [0:6][NUM_SC];
  logic signed [31:0] hu [0:6][NUM_SC];
  logic signed [31:0] ht [0:6][NUM_SC];
  logic [1:0]        hq [0:6][NUM_SC];
  logic [30:0]       s1_u [NUM_SC];

  always_comb begin
    for (int u = 0; u < NUM_SC; u++) begin
      s1_u[u] = 31'((s1_tt[u] + 62'(HALF_Q30)) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      for (int u = 0; u < NUM_SC; u++) begin
        hu[0][u] <= $signed({1'b0, s1_u[u]});
        ht[0][u] <= $signed({1'b0, s1_t[u]});
        hq[0][u] <= s1_q[u];
        hm[0][u] <= 64'(SIN_COEF[0]) * $signed({33'd0, s1_u[u]});
      end
    end
  end

  for (genvar gh = 1; gh <= 6; gh++) begin : g_horner
    logic signed [32:0] hp [NUM_SC];

    always_comb begin
      for (int u = 0; u < NUM_SC; u++) begin
        hp[u] = 33'(prod_t'(SIN_COEF[gh]) - rnd_q30(hm[gh-1][u]));
      end
    end

    always_ff @(posedge clk) begin
      if (ld[8+gh]) begin
        for (int u = 0; u < NUM_SC; u++) begin
          hu[gh][u] <= hu[gh-1][u];
          ht[gh][u] <= ht[gh-1][u];
          hq[gh][u] <= hq[gh-1][u];
          hm[gh][u] <= prod_t'(hp[u]) * prod_t'((gh < 6) ? hu[gh-1][u] : ht[gh-1][u]);
        end
      end
    end
  end

  // sine/cosine values carried down the link stages; index n at stage SC0+n
  q30_t scp [0:SCN][NUM_SC];
  prod_t sc_r [NUM_SC];
  q30_t  sc_m [NUM_SC];

  always_comb begin
    for (int u = 0; u < NUM_SC; u++) begin
      sc_r[u] = rnd_q30(hm[6][u]);
      if (sc_r[u] < 64'sd0) begin
        sc_m[u] = '0;
      end else if (sc_r[u] > ONE_Q30_W) begin
        sc_m[u] = Q30_ONE;
      end else begin
        sc_m[u] = 32'(sc_r[u]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int u = 0; u < NUM_SC; u++) begin
      if (ld[SC0]) begin
        scp[0][u] <= hq[6][u][1] ? -sc_m[u] : sc_m[u];
      end
      for (int n = 1; n <= SCN; n++) begin
        if (ld[SC0+n]) begin
          scp[n][u] <= scp[n-1][u];
        end
      end
    end
  end

  // ---------------- link chain: products, then sums ----------------
  q30_t     rot_s [NUM_JOINTS][3][3];
  pos_acc_t pos_s [NUM_JOINTS][3];

  for (genvar gi = 0; gi < NUM_JOINTS; gi++) begin : g_link
    localparam bit USE_R1 = (TWIST_COS[gi] != 0);
    localparam bit NEG_PS = USE_R1 ? (TWIST_COS[gi] < 0) : (TWIST_SIN[gi] < 0);
    localparam bit NEG_X2 = USE_R1 ? (TWIST_COS[gi] < 0) : (TWIST_SIN[gi] > 0);

    q30_t     rin [3][3];
    pos_acc_t pin [3];
    q30_t     ps  [3];
    q30_t     x2  [3];
    prod_t    lm  [3][6];
    q30_t     lx2 [3];
    pos_acc_t lpc [3];
    q30_t     cs, sn;

    assign sn = scp[2*gi][2*gi];
    assign cs = scp[2*gi][2*gi+1];

    if (gi == 0) begin : g_first
      always_comb begin
        for (int r = 0; r < 3; r++) begin
          pin[r] = '0;
          for (int k = 0; k < 3; k++) begin
            rin[r][k] = (r == k) ? Q30_ONE : '0;
          end
        end
      end
    end else begin : g_rest
      assign rin = rot_s[gi-1];
      assign pin = pos_s[gi-1];
    end

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        ps[r] = USE_R1 ? rin[r][1] : rin[r][2];
        if (NEG_PS) begin
          ps[r] = -ps[r];
        end
        x2[r] = USE_R1 ? rin[r][2] : rin[r][1];
        if (NEG_X2) begin
          x2[r] = -x2[r];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[LK0+2*gi]) begin
        for (int r = 0; r < 3; r++) begin
          lm[r][0] <= prod_t'(rin[r][0]) * prod_t'(cs);
          lm[r][1] <= prod_t'(rin[r][0]) * prod_t'(sn);
          lm[r][2] <= prod_t'(ps[r]) * prod_t'(sn);
          lm[r][3] <= prod_t'(ps[r]) * prod_t'(cs);
          lm[r][4] <= prod_t'(rin[r][0]) * prod_t'($signed({1'b0, len_a[gi]}));
          lm[r][5] <= prod_t'(x2[r]) * prod_t'($signed({1'b0, len_d[gi]}));
          lx2[r]   <= x2[r];
          lpc[r]   <= pin[r];
        end
      end
      if (ld[LK0+2*gi+1]) begin
        for (int r = 0; r < 3; r++) begin
          rot_s[gi][r][0] <= clamp_q30(rnd_q30(lm[r][0] + lm[r][2]));
          rot_s[gi][r][1] <= clamp_q30(rnd_q30(lm[r][3] - lm[r][1]));
          rot_s[gi][r][2] <= lx2[r];
          pos_s[gi][r]    <= lpc[r] + 32'(rnd_q30(lm[r][4] + lm[r][5]));
        end
      end
    end
  end

  // ---------------- output stage ----------------
  logic signed [ROT_W-1:0] rot_o [3][3];
  logic signed [POS_W-1:0] pos_o [3];
  prod_t rv [3][3];
  prod_t pw [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        rv[r][k] = (prod_t'(rot_s[NUM_JOINTS-1][r][k]) + RHALF) >>> RSH;
        if (rv[r][k] > RONE) begin
          rv[r][k] = RONE;
        end else if (rv[r][k] < -RONE) begin
          rv[r][k] = -RONE;
        end
      end
      pw[r] = prod_t'(pos_s[NUM_JOINTS-1][r]);
      if (pw[r] > POS_HI) begin
        pw[r] = POS_HI;
      end else if (pw[r] < POS_LO) begin
        pw[r] = POS_LO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NST]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          rot_o[r][k] <= ROT_W'(rv[r][k]);
        end
        pos_o[r] <= POS_W'(pw[r]);
      end
    end
  end

  assign rot_xx = rot_o[0][0];
  assign rot_xy = rot_o[0][1];
  assign rot_xz = rot_o[0][2];
  assign rot_yx = rot_o[1][0];
  assign rot_yy = rot_o[1][1];
  assign rot_yz = rot_o[1][2];
  assign rot_zx = rot_o[2][0];
  assign rot_zy = rot_o[2][1];
  assign rot_zz = rot_o[2][2];
  assign pos_x  = pos_o[0];
  assign pos_y  = pos_o[1];
  assign pos_z  = pos_o[2];

  // ---------------- assertions ----------------
  `RAFK_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && (&vld),
    "input stalled while pipeline has a hole")
  `RAFK_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld[1],
    "accepted item did not enter stage one")
  `RAFK_ASSERT_NXT(a_drain_empty, out_valid && !out_stall && !vld[NST-1], !out_valid,
    "output valid without an item behind it")
  `RAFK_ASSERT_IMP(a_rot_bound, out_valid,
    (prod_t'(rot_zz) <= RONE) && (prod_t'(rot_zz) >= -RONE),
    "rotation entry beyond one")

endmodule
